### src/fraction_insertion_sorter_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the fraction insertion sorter
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef FRACTION_INSERTION_SORTER_DEFINES_SVH
`define FRACTION_INSERTION_SORTER_DEFINES_SVH

// same-cycle implication
`define FIS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FIS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/fis_pkg.sv
// ----------------------------------------------------------------------------
// fis_pkg
// Types, sizes and the exact fraction compare shared by the sorter cells.
// ----------------------------------------------------------------------------
`default_nettype none

package fis_pkg;

  localparam int MAX_ITEMS_DEF = 16;
  localparam int FRAC_W        = 16;

  typedef struct packed {
    logic signed [FRAC_W-1:0] den;
    logic signed [FRAC_W-1:0] num;
  } frac_t;

  typedef struct packed {
    logic insert;
    logic drain;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    CLS_NEG_INF = 2'd0,
    CLS_FINITE  = 2'd1,
    CLS_POS_INF = 2'd2
  } val_class_t;

  function automatic val_class_t value_class(input logic signed [FRAC_W-1:0] n,
                                             input logic signed [FRAC_W-1:0] d);
    val_class_t c;
    if (d != '0) begin
      c = CLS_FINITE;
    end else if (n[FRAC_W-1]) begin
      c = CLS_NEG_INF;
    end else begin
      c = CLS_POS_INF;
    end
    return c;
  endfunction

  // true when a > b; a zero den is -inf/+inf by the num's sign; else dens made positive, then cross-multiplied
  function automatic logic greater_than(input frac_t a, input frac_t b);
    val_class_t               ca;
    val_class_t               cb;
    logic signed [FRAC_W:0]   n1;
    logic signed [FRAC_W:0]   n2;
    logic signed [FRAC_W+1:0] d1;
    logic signed [FRAC_W+1:0] d2;
    logic signed [2*FRAC_W+2:0] p1;
    logic signed [2*FRAC_W+2:0] p2;
    logic gt;
    ca = value_class(a.num, a.den);
    cb = value_class(b.num, b.den);
    n1 = (FRAC_W+1)'(a.num);
    n2 = (FRAC_W+1)'(b.num);
    d1 = (FRAC_W+2)'(a.den);
    d2 = (FRAC_W+2)'(b.den);
    if (a.den[FRAC_W-1]) begin
      n1 = -n1;
      d1 = -d1;
    end
    if (b.den[FRAC_W-1]) begin
      n2 = -n2;
      d2 = -d2;
    end
    p1 = (2*FRAC_W+3)'(n1) * (2*FRAC_W+3)'(d2);
    p2 = (2*FRAC_W+3)'(n2) * (2*FRAC_W+3)'(d1);
    if (ca != cb) begin
      gt = (ca > cb);
    end else begin
      gt = (ca == CLS_FINITE) && (p1 > p2);
    end
    return gt;
  endfunction

endpackage

`default_nettype wire

### src/fis_cell.sv
// ----------------------------------------------------------------------------
// fis_cell
// One slot of the sorted row: compares the incoming fraction against its own,
// shifts right on insert, shifts left on drain.
// ----------------------------------------------------------------------------
`default_nettype none

module fis_cell (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire fis_pkg::cell_ctrl_t ctrl,
  input  wire fis_pkg::frac_t      new_item,
  input  wire fis_pkg::frac_t      left_item,
  input  wire logic                left_valid,
  input  wire logic                left_gt,
  input  wire fis_pkg::frac_t      right_item,
  input  wire logic                right_valid,
  output fis_pkg::frac_t           held_item,
  output logic                     held_valid,
  output logic                     gt
);

  fis_pkg::frac_t item_r;
  fis_pkg::frac_t item_nxt;
  logic           valid_r;
  logic           valid_nxt;

  assign gt         = valid_r & fis_pkg::greater_than(item_r, new_item);
  assign held_item  = item_r;
  assign held_valid = valid_r;

  always_comb begin
    item_nxt  = item_r;
    valid_nxt = valid_r;
    if (ctrl.drain) begin
      item_nxt  = right_item;
      valid_nxt = right_valid;
    end else if (ctrl.insert && (gt || !valid_r) && left_valid) begin
      item_nxt  = left_gt ? left_item : new_item;
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

endmodule

`default_nettype wire

### src/fraction_insertion_sorter.sv
// ----------------------------------------------------------------------------
// fraction_insertion_sorter
// Stable ascending sort of signed fractions in a row of compare-and-shift
// cells; the set is streamed out in order after its last item.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)                | tlast        | tuser
//  in_     | in  | numerator, denominator            | is_last      | -
//  out_    | out | sorted_numerator, sorted_denom.   | end_of_set   | overflowed
//
//  Insertion takes one item per cycle while in_tready is high: all cells
//  compare in parallel. After the last item of a set, the held items
//  (up to MAX_ITEMS) follow on out transfers, out_tvalid rising the cycle
//  after that last transfer; in_tready is low until the final result is
//  taken, out_ stalls hold the row in place; sync reset empties the row.
// ----------------------------------------------------------------------------
`default_nettype none

module fraction_insertion_sorter #(
  parameter int MAX_ITEMS = fis_pkg::MAX_ITEMS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // numerator[15:0], denominator[31:16]
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // sorted_numerator[15:0], sorted_denominator[31:16]
  output logic             out_tlast,
  output logic [0:0]       out_tuser   // overflowed[0]
);

  fis_pkg::frac_t      new_item;
  fis_pkg::frac_t      item_w  [MAX_ITEMS];
  logic                valid_w [MAX_ITEMS];
  logic                gt_w    [MAX_ITEMS];
  fis_pkg::cell_ctrl_t ctrl;
  logic                in_xfer;
  logic                out_xfer;
  logic                full;
  logic                emit_r;
  logic                emit_nxt;
  logic                drop_r;
  logic                drop_nxt;

  assign new_item = fis_pkg::frac_t'(in_tdata);
  assign full     = valid_w[MAX_ITEMS-1];
  assign in_xfer  = in_tvalid & in_tready;
  assign out_xfer = out_tvalid & out_tready;

  assign ctrl = fis_pkg::cell_ctrl_t'{insert: in_xfer & ~full, drain: out_xfer};

  genvar i;
  generate
    for (i = 0; i < MAX_ITEMS; i++) begin : g_cell
      fis_pkg::frac_t left_item;
      logic           left_valid;
      logic           left_gt;
      fis_pkg::frac_t right_item;
      logic           right_valid;

      if (i == 0) begin : g_head
        assign left_item  = new_item;
        assign left_valid = 1'b1;
        assign left_gt    = 1'b0;
      end else begin : g_mid
        assign left_item  = item_w[i-1];
        assign left_valid = valid_w[i-1];
        assign left_gt    = gt_w[i-1];
      end

      if (i == MAX_ITEMS-1) begin : g_tail
        assign right_item  = item_w[i];
        assign right_valid = 1'b0;
      end else begin : g_body
        assign right_item  = item_w[i+1];
        assign right_valid = valid_w[i+1];
      end

      fis_cell u_cell (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .new_item    (new_item),
        .left_item   (left_item),
        .left_valid  (left_valid),
        .left_gt     (left_gt),
        .right_item  (right_item),
        .right_valid (right_valid),
        .held_item   (item_w[i]),
        .held_valid  (valid_w[i]),
        .gt          (gt_w[i])
      );
    end
  endgenerate

  assign in_tready    = ~emit_r;
  assign out_tvalid   = emit_r & valid_w[0];
  assign out_tdata    = 32'(item_w[0]);
  assign out_tlast    = ~valid_w[1];
  assign out_tuser[0] = drop_r;

  always_comb begin
    emit_nxt = emit_r;
    drop_nxt = drop_r;
    if (in_xfer && full) begin
      drop_nxt = 1'b1;
    end
    if (in_xfer && in_tlast) begin
      emit_nxt = 1'b1;
    end
    if (out_xfer && out_tlast) begin
      emit_nxt = 1'b0;
      drop_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emit_r <= 1'b0;
      drop_r <= 1'b0;
    end else begin
      emit_r <= emit_nxt;
      drop_r <= drop_nxt;
    end
  end

endmodule

`default_nettype wire

### src/fis_checker.sv
// ----------------------------------------------------------------------------
// fis_checker
// Port-level checks of the load / emit sequencing of the sorter.
// ----------------------------------------------------------------------------
`default_nettype none

`include "fraction_insertion_sorter_defines.svh"

module fis_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        in_tlast,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata,
  input wire logic        out_tlast,
  input wire logic [0:0]  out_tuser
);

  `FIS_ASSERT_NOW(a_no_load_while_emit, clk, rst_n, out_tvalid, !in_tready, "input open during emit")
  `FIS_ASSERT_NEXT(a_emit_after_last, clk, rst_n, in_tvalid && in_tready && in_tlast, out_tvalid && !in_tready, "no result after last transfer")
  `FIS_ASSERT_NEXT(a_ready_after_set, clk, rst_n, out_tvalid && out_tready && out_tlast, in_tready && !out_tvalid, "input not reopened after set")
  `FIS_ASSERT_NEXT(a_hold_on_stall, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast), "stalled result changed")
  `FIS_ASSERT_NEXT(a_flag_steady, clk, rst_n, out_tvalid && out_tready && !out_tlast, out_tvalid && $stable(out_tuser), "overflow flag changed within set")

endmodule

bind fraction_insertion_sorter fis_checker u_fis_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

`default_nettype wire
